>>> src/isort_pkg.sv
// Package with shared constants and types of the insertion sorter.
package isort_pkg;

  localparam int unsigned DEPTH = 16;
  localparam int unsigned KEY_W = 32;

  typedef struct packed {
    logic insert;
    logic shift;
  } cell_ctrl_t;

endpackage

>>> src/isort_cell.sv
// One compare-and-shift cell of the insertion sorter chain.
module isort_cell (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  isort_pkg::cell_ctrl_t                ctrl_i,
  input  logic signed [isort_pkg::KEY_W-1:0]   new_key_i,
  input  logic signed [isort_pkg::KEY_W-1:0]   left_key_i,
  input  logic                                 left_valid_i,
  input  logic                                 left_gt_i,
  input  logic signed [isort_pkg::KEY_W-1:0]   right_key_i,
  input  logic                                 right_valid_i,
  output logic signed [isort_pkg::KEY_W-1:0]   key_o,
  output logic                                 valid_o,
  output logic                                 gt_o
);

  logic signed [isort_pkg::KEY_W-1:0] key_q, key_d;
  logic                               valid_q, valid_d;

  // The cell holds a key greater than the one being inserted.
  assign gt_o = valid_q && (key_q > new_key_i);

  always_comb begin
    key_d   = key_q;
    valid_d = valid_q;
    if (ctrl_i.shift) begin
      key_d   = right_key_i;
      valid_d = right_valid_i;
    end else if (ctrl_i.insert && (!valid_q || gt_o)) begin
      // Empty cells and cells with larger keys move up; the new key lands
      // where the left neighbor is no longer larger.
      key_d   = left_gt_i ? left_key_i : new_key_i;
      valid_d = valid_q || left_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

  assign key_o   = key_q;
  assign valid_o = valid_q;

endmodule

>>> src/insertion_sorter.sv
// Top level of the streaming insertion sorter built from a chain of cells.
//
//   Channel  Dir  tdata                    tlast
//   s_axis   in   [31:0] key_value         set_end
//   m_axis   out  [31:0] sorted_key        run_end
//
// Loading accepts one key per cycle: every cell compares its key with the
// incoming one in parallel and the chain opens a gap in a single step.
// The key that ends a set (set_end, or the key that fills all DEPTH cells)
// switches the chain to draining, which shifts one key toward cell 0 each
// cycle that the master side accepts a transaction; s_axis_tready is low
// while draining. Output stalls simply hold the chain. Reset clears the
// valid bits of all cells and the drain flag; key registers are not
// reset.
module insertion_sorter (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] key_value
  input  logic        s_axis_tlast,   // set_end
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] sorted_key
  output logic        m_axis_tlast    // run_end
);

  localparam int unsigned N = isort_pkg::DEPTH;

  logic signed [isort_pkg::KEY_W-1:0] key_w   [N];
  logic [N-1:0]                       valid_w;
  logic [N-1:0]                       gt_w;
  logic signed [isort_pkg::KEY_W-1:0] new_key;
  isort_pkg::cell_ctrl_t              ctrl;
  logic                               drain_q, drain_d;
  logic                               in_fire, out_fire;

  assign new_key = $signed(s_axis_tdata);

  // Inputs are taken only while loading; the chain is busy when draining.
  assign s_axis_tready = !drain_q;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  // Cell 0 always holds the smallest remaining key during the drain.
  assign m_axis_tvalid = drain_q && valid_w[0];
  assign m_axis_tdata  = key_w[0];
  assign m_axis_tlast  = !valid_w[1];
  assign out_fire      = m_axis_tvalid && m_axis_tready;

  assign ctrl.insert = in_fire;
  assign ctrl.shift  = out_fire;

  // Enter the drain on the set's final key, or when this key fills the
  // chain (the cell next to the top was already occupied). Leave it once
  // the final key has been handed over.
  always_comb begin
    drain_d = drain_q;
    if (in_fire && (s_axis_tlast || valid_w[N-2])) begin
      drain_d = 1'b1;
    end else if (out_fire && m_axis_tlast) begin
      drain_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drain_q <= 1'b0;
    end else begin
      drain_q <= drain_d;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_cell
    logic signed [isort_pkg::KEY_W-1:0] left_key, right_key;
    logic                               left_valid, left_gt, right_valid;

    if (i == 0) begin : g_first
      assign left_key   = new_key;
      assign left_valid = 1'b1;
      assign left_gt    = 1'b0;
    end else begin : g_mid_l
      assign left_key   = key_w[i-1];
      assign left_valid = valid_w[i-1];
      assign left_gt    = gt_w[i-1];
    end

    if (i == N - 1) begin : g_last
      assign right_key   = key_w[i];
      assign right_valid = 1'b0;
    end else begin : g_mid_r
      assign right_key   = key_w[i+1];
      assign right_valid = valid_w[i+1];
    end

    isort_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctrl_i        (ctrl),
      .new_key_i     (new_key),
      .left_key_i    (left_key),
      .left_valid_i  (left_valid),
      .left_gt_i     (left_gt),
      .right_key_i   (right_key),
      .right_valid_i (right_valid),
      .key_o         (key_w[i]),
      .valid_o       (valid_w[i]),
      .gt_o          (gt_w[i])
    );
  end

  // Occupied cells always form one run starting at cell 0.
  a_valid_contig: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((valid_w >> 1) & ~valid_w) == '0)
    else $error("chain has a hole in its occupied cells");

  // The two lowest cells stay in ascending order.
  a_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_w[1] |-> (key_w[0] <= key_w[1]))
    else $error("chain is out of order");

  // A final key starts the drain.
  a_end_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && s_axis_tlast) |=> drain_q)
    else $error("set end did not start the drain");

  // Handing over the final key empties the chain and resumes loading.
  a_drain_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_fire && m_axis_tlast) |=> (!drain_q && valid_w == '0))
    else $error("chain not empty after the final key");

  // No drain runs on an empty chain.
  a_drain_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    drain_q |-> valid_w[0])
    else $error("drain with an empty chain");

endmodule

>>> test/insertion_sorter_test.sv
// Self-checking testbench for the streaming insertion sorter.
module insertion_sorter_test;
  timeunit 1ns;
  timeprecision 1ps;

  // Cycles without any accepted transaction before the run is declared hung.
  localparam int unsigned STALL_LIMIT  = 1000;
  // Quiet cycles after the last result, enough to drain a full chain twice.
  localparam int unsigned DRAIN_CYCLES = 2 * isort_pkg::DEPTH + 8;
  // Number of keys sent in the random part.
  localparam int unsigned RANDOM_ITEMS = 200;

  // One expected output transaction: a sorted key and its end-of-run mark.
  typedef struct packed {
    logic [isort_pkg::KEY_W-1:0] key;
    logic                        last;
  } sorted_item_t;

  // Scoreboard: keeps its own sorted copy of the set being loaded and the
  // queue of sorted keys that the block still owes.
  class sort_scoreboard;
    logic signed [isort_pkg::KEY_W-1:0] held_keys [isort_pkg::DEPTH];
    int unsigned                        held = 0;
    sorted_item_t                       awaited [$];
    int unsigned                        errors = 0;

    // Inserts one accepted key; on the end of a set, queues the whole set.
    function void note_key(logic signed [isort_pkg::KEY_W-1:0] key, logic last);
      int unsigned  pos;
      sorted_item_t item;
      if (held >= isort_pkg::DEPTH) held = 0;
      pos = held;
      while (pos > 0 && held_keys[pos-1] > key) begin
        held_keys[pos] = held_keys[pos-1];
        pos--;
      end
      held_keys[pos] = key;
      held++;
      // A full store ends the set even without the last mark.
      if (last || held == isort_pkg::DEPTH) begin
        for (int unsigned k = 0; k < held; k++) begin
          item.key  = held_keys[k];
          item.last = (k + 1 == held);
          awaited.push_back(item);
        end
        held = 0;
      end
    endfunction

    // Compares one accepted result with the oldest expected one.
    function void check_result(logic [isort_pkg::KEY_W-1:0] key, logic last);
      sorted_item_t want;
      if (awaited.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: key %0d last %0b", $signed(key), last);
      end else begin
        want = awaited.pop_front();
        if (want.key !== key || want.last !== last) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: expected key %0d last %0b, got key %0d last %0b",
                     $signed(want.key), want.last, $signed(key), last);
        end
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;   // [31:0] key_value
  logic        s_axis_tlast;   // set_end
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;   // [31:0] sorted_key
  logic        m_axis_tlast;   // run_end

  sort_scoreboard board = new;

  // When set, neither side inserts idle cycles any more.
  bit          quiet = 1'b0;
  int unsigned stall_cycles = 0;

  insertion_sorter u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  // 12 ns clock period.
  always #6 clk_i = ~clk_i;

  // Sends one key. Called at a falling edge and returns at a falling edge,
  // so all inputs change only on falling edges. An optional idle burst goes
  // in front of the key; tvalid then stays high until the key is accepted.
  task automatic send_key(input logic [isort_pkg::KEY_W-1:0] key, input logic last);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= key;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  // Random key: half full-range values, with extremes and a narrow range
  // mixed in so that equal keys and sign boundaries show up often.
  function automatic logic [isort_pkg::KEY_W-1:0] pick_key();
    case ($urandom_range(0, 7))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2, 3:    return 32'($urandom_range(0, 15)) - 32'd8;
      default: return $urandom;
    endcase
  endfunction

  // Master side: ready toggles in random bursts, updated only on falling edges.
  always begin
    @(negedge clk_i);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      m_axis_tready <= 1'b0;
      repeat ($urandom_range(1, 16) - 1) @(negedge clk_i);
    end else begin
      m_axis_tready <= 1'b1;
      repeat ($urandom_range(0, 15)) @(negedge clk_i);
    end
  end

  // Monitor: samples both channels at the rising edge, feeds the scoreboard
  // and watches for a hung block.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready)
        board.note_key(s_axis_tdata, s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready)
        board.check_result(m_axis_tdata, m_axis_tlast);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
      if (stall_cycles >= STALL_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    int unsigned sent;
    int unsigned len;
    bit          open;

    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    rst_ni        = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part. Sets of a single key at each extreme.
    send_key(32'h8000_0000, 1'b1);
    send_key(32'h7fff_ffff, 1'b1);
    // A mixed set across the sign boundary, with a repeated key.
    send_key(32'h7fff_ffff, 1'b0);
    send_key(32'h8000_0000, 1'b0);
    send_key(32'h0000_0000, 1'b0);
    send_key(32'hffff_ffff, 1'b0);
    send_key(32'h0000_0001, 1'b0);
    send_key(32'hffff_ffff, 1'b1);
    // Descending pairs with no last mark: the full store ends the set.
    for (int i = 0; i < isort_pkg::DEPTH; i++)
      send_key(32'(1000 - 100 * (i / 2)), 1'b0);

    // Hold the sender off until every sorted key has come out.
    s_axis_tvalid <= 1'b0;
    do @(negedge clk_i); while (board.awaited.size() != 0);

    // Random part: mostly well-formed sets of short length, some full ones,
    // and some sets without a last mark that run into the next set or into
    // the full-store end.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0:       len = isort_pkg::DEPTH;
        1:       len = isort_pkg::DEPTH + $urandom_range(1, 5);
        default: len = $urandom_range(1, 8);
      endcase
      open = ($urandom_range(0, 7) == 0);
      for (int unsigned i = 0; i < len; i++) begin
        // The last fifth of the run goes without any idle cycles.
        if (sent >= RANDOM_ITEMS * 4 / 5) quiet = 1'b1;
        send_key(pick_key(), (i == len - 1) && !open);
        sent++;
      end
    end
    s_axis_tvalid <= 1'b0;

    // Wait for the last results; the watchdog covers a block that hangs.
    while (board.awaited.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (board.errors == 0 && board.awaited.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
